FILE: rtl/ube_pkg.sv
// Shared types, constants and helper functions of the unambiguous byte escaper.
package ube_pkg;

    // Character codes used by the renderer.
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TILDE     = 8'h7E;

    // Input kind codes carried on tuser.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Reset value of the line width register.
    localparam logic [7:0] LINE_WIDTH_RESET = 8'd72;

    // Default depth of the queue between front and back.
    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Longest character sequence one item can cause, and the step counter width.
    localparam int MAX_CHARS  = 6;
    localparam int STEP_WIDTH = $clog2(MAX_CHARS);

    // Kind of piece the back end has to render.
    typedef enum logic [1:0] {
        PIECE_PLAIN,
        PIECE_SHORT,
        PIECE_OCTAL,
        PIECE_EOL
    } piece_t;

    // One job handed from the front to the back.
    typedef struct packed {
        logic       wrap;
        piece_t     piece;
        logic [7:0] data;
    } job_t;

    // Second character of a two-character escape, or zero if there is none.
    function automatic logic [7:0] short_escape(input logic [7:0] b);
        logic [7:0] esc;
        begin
            unique case (b)
                8'h07:   esc = 8'h61; // a
                8'h08:   esc = 8'h62; // b
                8'h0C:   esc = 8'h66; // f
                8'h0A:   esc = 8'h6E; // n
                8'h0D:   esc = 8'h72; // r
                8'h09:   esc = 8'h74; // t
                8'h0B:   esc = 8'h76; // v
                8'h5C:   esc = CHAR_BACKSLASH;
                default: esc = 8'h00;
            endcase
            return esc;
        end
    endfunction

endpackage

FILE: rtl/ube_front.sv
// Front end: accepts items, classifies each byte and keeps the output column count.
module ube_front
    import ube_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input item channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] kind
    // Queue write side.
    input  logic       fifo_full,
    output logic       push,
    output job_t       push_job
);

    logic [7:0] line_width_reg;
    logic [7:0] line_width_next;
    logic [7:0] column_count_reg;
    logic [7:0] column_count_next;

    logic [7:0] esc_char;
    piece_t     piece;
    logic [2:0] piece_width;
    logic [8:0] sum;
    logic       wrap;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && s_tready;

    // Classify the byte and decide on a continuation.
    always_comb begin
        esc_char = short_escape(s_tdata);
        if (s_tuser == KIND_EOL) begin
            piece = PIECE_EOL;
        end else if (s_tdata >= CHAR_SPACE && s_tdata <= CHAR_TILDE
                     && s_tdata != CHAR_BACKSLASH) begin
            piece = PIECE_PLAIN;
        end else if (esc_char != 8'h00) begin
            piece = PIECE_SHORT;
        end else begin
            piece = PIECE_OCTAL;
        end

        case (piece)
            PIECE_PLAIN: piece_width = 3'd1;
            PIECE_SHORT: piece_width = 3'd2;
            default:     piece_width = 3'd4;
        endcase

        sum  = {1'b0, column_count_reg} + {6'd0, piece_width};
        wrap = (piece != PIECE_EOL) && (sum >= {1'b0, line_width_reg});

        push_job.wrap  = wrap;
        push_job.piece = piece;
        push_job.data  = (piece == PIECE_SHORT) ? esc_char : s_tdata;
    end

    // Next values of the column count and the line width.
    always_comb begin
        column_count_next = column_count_reg;
        if (push) begin
            if (piece == PIECE_EOL) begin
                column_count_next = 8'd0;
            end else if (wrap) begin
                column_count_next = {5'd0, piece_width};
            end else begin
                column_count_next = sum[7:0];
            end
        end
        line_width_next = (cfg_valid && cfg_ready) ? cfg_data : line_width_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= 8'd0;
            line_width_reg   <= LINE_WIDTH_RESET;
        end else begin
            column_count_reg <= column_count_next;
            line_width_reg   <= line_width_next;
        end
    end

endmodule

FILE: rtl/ube_fifo.sv
// Short job queue that decouples the front end from the back end.
module ube_fifo
    import ube_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

    job_t                 slots_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/ube_back.sv
// Back end: expands each queued job into output characters, one per cycle while the result channel accepts them.
module ube_back
    import ube_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Queue read side.
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    // Result channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last
);

    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [7:0]            m_tdata_reg;
    logic [7:0]            m_tdata_next;
    logic                  m_tlast_reg;
    logic                  m_tlast_next;

    logic                  load;
    logic [STEP_WIDTH-1:0] wrap_len;
    logic [STEP_WIDTH-1:0] body_len;
    logic [STEP_WIDTH-1:0] total_len;
    logic [STEP_WIDTH-1:0] body_step;
    logic [7:0]            cur_char;
    logic                  cur_last;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The output register takes a new character when it is empty or being drained.
    assign load = head_valid && (!m_tvalid_reg || m_tready);
    assign pop  = load && cur_last;

    // Character at the current step of the head job.
    always_comb begin
        wrap_len = head_job.wrap ? STEP_WIDTH'(2) : '0;
        case (head_job.piece)
            PIECE_PLAIN: body_len = STEP_WIDTH'(1);
            PIECE_OCTAL: body_len = STEP_WIDTH'(4);
            default:     body_len = STEP_WIDTH'(2);
        endcase
        total_len = wrap_len + body_len;
        body_step = step_reg - wrap_len;
        cur_last  = (step_reg == total_len - 1'b1);

        if (step_reg < wrap_len) begin
            cur_char = (step_reg == '0) ? CHAR_BACKSLASH : CHAR_NEWLINE;
        end else begin
            unique case (head_job.piece)
                PIECE_PLAIN: cur_char = head_job.data;
                PIECE_SHORT: cur_char = (body_step == '0) ? CHAR_BACKSLASH : head_job.data;
                PIECE_EOL:   cur_char = (body_step == '0) ? CHAR_DOLLAR : CHAR_NEWLINE;
                default: begin
                    // Backslash followed by three octal digits, most significant first.
                    case (body_step)
                        STEP_WIDTH'(1): cur_char = {6'b001100, head_job.data[7:6]};
                        STEP_WIDTH'(2): cur_char = {5'b00110, head_job.data[5:3]};
                        STEP_WIDTH'(3): cur_char = {5'b00110, head_job.data[2:0]};
                        default:        cur_char = CHAR_BACKSLASH;
                    endcase
                end
            endcase
        end
    end

    // Step counter and output register next values.
    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            step_next     = cur_last ? '0 : step_reg + 1'b1;
            m_tvalid_next = 1'b1;
            m_tdata_next  = cur_char;
            m_tlast_next  = cur_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

FILE: rtl/unambiguous_byte_escaper_core.sv
// Path: an accepted item is written into the job queue, and its first character then enters the
// output register, which drives the result channel; each further character follows when not stalled.
// Throughput: one character per cycle while jobs are queued and m_tready holds; an item causes one
// to six characters, so the output register and its step counter set the rate.
// The front end accepts one item per cycle while the job queue has room.
// Reset (aresetn low, synchronous) empties the queue, clears the column count and
// sets the line width to 72; no clearing pass is needed.
module unambiguous_byte_escaper_core
    import ube_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel: line_width.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // Input item channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] kind
    // Result item channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last
);

    logic push;
    job_t push_job;
    logic fifo_full;
    logic pop;
    logic head_valid;
    job_t head_job;

    // Classification and column tracking.
    ube_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue between the two halves.
    ube_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Character generation.
    ube_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTH
    // A job leaves the queue only while one is present.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head_valid)
        else $error("job popped from an empty queue");

    // A job leaves the queue only when its final character enters a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!m_tvalid || m_tready))
        else $error("job popped while the output register is stalled");

    // The final character of a job always carries the last flag in the cycle after its pop.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |=> (m_tvalid && m_tlast))
        else $error("job completed without a last character");

    // A full queue always holds a job.
    assert property (@(posedge aclk) disable iff (!aresetn) fifo_full |-> head_valid)
        else $error("queue reports full and empty at once");
`endif

endmodule
